// ===== sv/dsu_pkg.sv =====
// Package for the disjoint-set engine: shared constants, controller states,
// and the command and status bundles between controller and datapath.
// Has no dependencies.
package dsu_pkg;

    localparam int unsigned MAX_NODES_DEF = 1024;
    localparam int unsigned CNT_W         = 11;
    localparam int unsigned COUNT_LIMIT   = 2047;
    localparam int unsigned RESET_COUNT   = 1024;

    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_JOIN  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_F1_RD,
        S_F1_EV,
        S_F2_RD,
        S_F2_WR,
        S_J1,
        S_J2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_cfg;
        logic clr_write;
        logic accept;
        logic start_b;
        logic f1_read;
        logic f1_step;
        logic f1_root;
        logic f2_read;
        logic f2_write;
        logic join_win;
        logic join_lose;
        logic out_load;
        logic sel_b;
    } cmd_t;

    typedef struct packed {
        logic in_err;
        logic clr_last;
        logic is_root;
        logic f2_done;
        logic need_join;
    } status_t;

endpackage

// ===== sv/disjoint_set_union_find.sv =====
// Top level of the disjoint-set engine, joining controller and datapath.
// Depends on dsu_pkg, dsu_ctrl and dsu_datapath.
//
// Union-find over nodes 1 to node_count with union by size and path
// compression; each transaction checks or joins two nodes and returns the
// same-set answer and the number of sets. The node table sits in one
// single-port memory: an item with a bad index skips the root searches, and
// for any other item every parent link walked is read in the root search and
// read again and rewritten with the root in the compressing pass, and a join
// writes two more entries. After reset and after every node_count write the
// memory is cleared, during which no transaction is accepted. A result waits
// in an output register while the next transaction is accepted.
module disjoint_set_union_find
#(
    parameter int unsigned MAX_NODES = dsu_pkg::MAX_NODES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      op,
    input  logic [dsu_pkg::CNT_W-1:0] first_node,
    input  logic [dsu_pkg::CNT_W-1:0] second_node,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      same_set,
    output logic [dsu_pkg::CNT_W-1:0] component_count,
    output logic                      index_error,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [dsu_pkg::CNT_W-1:0] cfg_data
);

    dsu_pkg::cmd_t    cmd;
    dsu_pkg::status_t status;

    dsu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dsu_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .op              (op),
        .first_node      (first_node),
        .second_node     (second_node),
        .cfg_data        (cfg_data),
        .same_set        (same_set),
        .component_count (component_count),
        .index_error     (index_error)
    );

endmodule

// ===== sv/dsu_ctrl.sv =====
// Controller state machine of the disjoint-set engine.
// Sequences clearing, root searches, path compression, joins and output.
// Depends on dsu_pkg.
module dsu_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  dsu_pkg::status_t status,
    output dsu_pkg::cmd_t    cmd
);

    dsu_pkg::state_t state_reg;
    dsu_pkg::state_t state_next;
    logic            phase_b_reg;
    logic            phase_b_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dsu_pkg::S_CLEAR;
            phase_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_b_reg   <= phase_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == dsu_pkg::S_IDLE) && !cfg_valid;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.sel_b      = phase_b_reg;
        state_next     = state_reg;
        phase_b_next   = phase_b_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cfg_valid)
        begin
            cmd.load_cfg = 1'b1;
            state_next   = dsu_pkg::S_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                dsu_pkg::S_CLEAR:
                begin
                    cmd.clr_write = 1'b1;
                    if (status.clr_last)
                    begin
                        state_next = dsu_pkg::S_IDLE;
                    end
                end
                dsu_pkg::S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd.accept   = 1'b1;
                        phase_b_next = 1'b0;
                        state_next   = status.in_err ? dsu_pkg::S_DONE : dsu_pkg::S_F1_RD;
                    end
                end
                dsu_pkg::S_F1_RD:
                begin
                    cmd.f1_read = 1'b1;
                    state_next  = dsu_pkg::S_F1_EV;
                end
                dsu_pkg::S_F1_EV:
                begin
                    if (status.is_root)
                    begin
                        cmd.f1_root = 1'b1;
                        state_next  = dsu_pkg::S_F2_RD;
                    end
                    else
                    begin
                        cmd.f1_step = 1'b1;
                        state_next  = dsu_pkg::S_F1_RD;
                    end
                end
                dsu_pkg::S_F2_RD:
                begin
                    if (!status.f2_done)
                    begin
                        cmd.f2_read = 1'b1;
                        state_next  = dsu_pkg::S_F2_WR;
                    end
                    else if (!phase_b_reg)
                    begin
                        cmd.start_b  = 1'b1;
                        phase_b_next = 1'b1;
                        state_next   = dsu_pkg::S_F1_RD;
                    end
                    else if (status.need_join)
                    begin
                        state_next = dsu_pkg::S_J1;
                    end
                    else
                    begin
                        state_next = dsu_pkg::S_DONE;
                    end
                end
                dsu_pkg::S_F2_WR:
                begin
                    cmd.f2_write = 1'b1;
                    state_next   = dsu_pkg::S_F2_RD;
                end
                dsu_pkg::S_J1:
                begin
                    cmd.join_win = 1'b1;
                    state_next   = dsu_pkg::S_J2;
                end
                dsu_pkg::S_J2:
                begin
                    cmd.join_lose = 1'b1;
                    state_next    = dsu_pkg::S_DONE;
                end
                dsu_pkg::S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        cmd.out_load   = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = dsu_pkg::S_IDLE;
                    end
                end
                default:
                begin
                    state_next = dsu_pkg::S_CLEAR;
                end
            endcase
        end
    end

endmodule

// ===== sv/dsu_datapath.sv =====
// Datapath of the disjoint-set engine: node table memory, search registers,
// node count and merge count, and the output register. Depends on dsu_pkg.
module dsu_datapath
#(
    parameter int unsigned MAX_NODES = dsu_pkg::MAX_NODES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dsu_pkg::cmd_t             cmd,
    output dsu_pkg::status_t          status,
    input  logic                      op,
    input  logic [dsu_pkg::CNT_W-1:0] first_node,
    input  logic [dsu_pkg::CNT_W-1:0] second_node,
    input  logic [dsu_pkg::CNT_W-1:0] cfg_data,
    output logic                      same_set,
    output logic [dsu_pkg::CNT_W-1:0] component_count,
    output logic                      index_error
);

    localparam int unsigned CNT_W  = dsu_pkg::CNT_W;
    localparam int unsigned DEPTH  = (MAX_NODES < dsu_pkg::COUNT_LIMIT) ?
                                     MAX_NODES : dsu_pkg::COUNT_LIMIT;
    localparam int unsigned ADDR_W = $clog2(DEPTH + 1);
    localparam int unsigned INIT_COUNT = (dsu_pkg::RESET_COUNT < DEPTH) ?
                                         dsu_pkg::RESET_COUNT : DEPTH;

    // An entry is a root flag over either a set size or a parent index.
    logic [ADDR_W:0]   mem [0:DEPTH];
    logic [ADDR_W:0]   rd_data_reg;

    logic [CNT_W-1:0]  node_count_reg;
    logic [CNT_W-1:0]  merge_count_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    logic              op_reg;
    logic              err_reg;
    logic [ADDR_W-1:0] b_reg;
    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] cur_reg;
    logic [ADDR_W-1:0] ra_reg;
    logic [ADDR_W-1:0] rb_reg;
    logic [ADDR_W-1:0] size_a_reg;
    logic [ADDR_W-1:0] size_b_reg;
    logic              same_set_reg;
    logic [CNT_W-1:0]  component_count_reg;
    logic              index_error_reg;

    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [ADDR_W:0]   mem_wdata;
    logic [ADDR_W-1:0] cur_root;
    logic [ADDR_W-1:0] rd_link;
    logic              a_wins;
    logic [ADDR_W-1:0] win_root;
    logic [ADDR_W-1:0] lose_root;
    logic [ADDR_W-1:0] size_sum;
    logic [CNT_W-1:0]  cfg_sat;

    assign cur_root  = cmd.sel_b ? rb_reg : ra_reg;
    assign rd_link   = rd_data_reg[ADDR_W-1:0];
    assign a_wins    = size_a_reg > size_b_reg;
    assign win_root  = a_wins ? ra_reg : rb_reg;
    assign lose_root = a_wins ? rb_reg : ra_reg;
    assign size_sum  = size_a_reg + size_b_reg;

    assign status.in_err    = (first_node == '0) || (first_node > node_count_reg) ||
                              (second_node == '0) || (second_node > node_count_reg);
    assign status.clr_last  = (clr_cnt_reg == ADDR_W'(DEPTH));
    assign status.is_root   = rd_data_reg[ADDR_W];
    assign status.f2_done   = (cur_reg == cur_root);
    assign status.need_join = (op_reg == dsu_pkg::OP_JOIN) && (ra_reg != rb_reg);

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_sat = CNT_W'(1);
        end
        else if (cfg_data > CNT_W'(DEPTH))
        begin
            cfg_sat = CNT_W'(DEPTH);
        end
        else
        begin
            cfg_sat = cfg_data;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = cur_reg;
        mem_wdata = '0;
        priority if (cmd.clr_write)
        begin
            mem_we    = 1'b1;
            mem_addr  = clr_cnt_reg;
            mem_wdata = {1'b1, ADDR_W'(1)};
        end
        else if (cmd.f1_read || cmd.f2_read)
        begin
            mem_re = 1'b1;
        end
        else if (cmd.f2_write)
        begin
            mem_we    = 1'b1;
            mem_wdata = {1'b0, cur_root};
        end
        else if (cmd.join_win)
        begin
            mem_we    = 1'b1;
            mem_addr  = win_root;
            mem_wdata = {1'b1, size_sum};
        end
        else if (cmd.join_lose)
        begin
            mem_we    = 1'b1;
            mem_addr  = lose_root;
            mem_wdata = {1'b0, win_root};
        end
        else
        begin
            mem_re = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        else if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= CNT_W'(INIT_COUNT);
            merge_count_reg <= '0;
            clr_cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.load_cfg)
            begin
                node_count_reg  <= cfg_sat;
                merge_count_reg <= '0;
                clr_cnt_reg     <= '0;
            end
            else
            begin
                if (cmd.clr_write)
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                if (cmd.join_lose)
                begin
                    merge_count_reg <= merge_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= op;
            err_reg   <= status.in_err;
            b_reg     <= second_node[ADDR_W-1:0];
            cur_reg   <= first_node[ADDR_W-1:0];
            start_reg <= first_node[ADDR_W-1:0];
        end
        if (cmd.start_b)
        begin
            cur_reg   <= b_reg;
            start_reg <= b_reg;
        end
        if (cmd.f1_step || cmd.f2_write)
        begin
            cur_reg <= rd_link;
        end
        if (cmd.f1_root)
        begin
            if (cmd.sel_b)
            begin
                rb_reg     <= cur_reg;
                size_b_reg <= rd_link;
            end
            else
            begin
                ra_reg     <= cur_reg;
                size_a_reg <= rd_link;
            end
            cur_reg <= start_reg;
        end
        if (cmd.out_load)
        begin
            same_set_reg        <= !err_reg && (ra_reg == rb_reg);
            component_count_reg <= node_count_reg - merge_count_reg;
            index_error_reg     <= err_reg;
        end
    end

    assign same_set        = same_set_reg;
    assign component_count = component_count_reg;
    assign index_error     = index_error_reg;

endmodule

// ===== sv/dsu_checker.sv =====
// Port-level checks for the disjoint-set engine, bound to the top level.
// Depends on dsu_pkg and disjoint_set_union_find.
module dsu_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      same_set,
    input logic [dsu_pkg::CNT_W-1:0] component_count,
    input logic                      index_error,
    input logic                      cfg_valid,
    input logic                      cfg_ready
);

    // An accepted transaction keeps the engine busy, so two are never accepted back to back.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on two consecutive cycles");

    // A register write starts the clearing pass.
    a_clear_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !in_ready)
        else $error("input ready right after a node_count write");

    a_error_not_same: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_error |-> !same_set)
        else $error("same_set reported on an index error");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> component_count != '0)
        else $error("component count reached zero");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(same_set) &&
        $stable(component_count) && $stable(index_error))
        else $error("stalled result changed");

endmodule

bind disjoint_set_union_find dsu_checker u_checker (.*);

// ===== verif/disjoint_set_union_find_test.sv =====
// Self-checking testbench for the disjoint_set_union_find engine.
// Depends on dsu_pkg and the disjoint_set_union_find top level. It predicts
// every result with its own union-find table and checks each one in order.
module disjoint_set_union_find_test;

    localparam int unsigned CNT_W       = dsu_pkg::CNT_W;
    localparam logic        OP_CHECK    = dsu_pkg::OP_CHECK;
    localparam logic        OP_JOIN     = dsu_pkg::OP_JOIN;
    localparam int          TABLE_DEPTH = dsu_pkg::MAX_NODES_DEF;

    typedef struct {
        logic             same_set;
        logic [CNT_W-1:0] component_count;
        logic             index_error;
    } outcome_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic             op;
    logic [CNT_W-1:0] first_node;
    logic [CNT_W-1:0] second_node;
    logic             out_valid;
    logic             out_ready;
    logic             same_set;
    logic [CNT_W-1:0] component_count;
    logic             index_error;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    logic signed [11:0] parent_of [0:TABLE_DEPTH];
    logic [CNT_W-1:0]   node_limit;
    logic [CNT_W-1:0]   merged_sets;

    outcome_t pending_outcomes [$];
    outcome_t want;

    int  error_count;
    int  transactions_sent;
    int  results_checked;
    int  settings_used;
    int  total_merges;
    int  hold_off_cycles;
    bit  no_idle;

    disjoint_set_union_find u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .first_node      (first_node),
        .second_node     (second_node),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .same_set        (same_set),
        .component_count (component_count),
        .index_error     (index_error),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_link(input logic signed [11:0] v);
        return v >= 12'sd1 && v <= 12'sd1024;
    endfunction

    function automatic logic [CNT_W-1:0] locate_root(input logic [CNT_W-1:0] start);
        logic [CNT_W-1:0] root;
        logic [CNT_W-1:0] walk;
        logic [CNT_W-1:0] next_node;
        int               steps;
        root  = start;
        walk  = start;
        steps = 0;
        while (is_link(parent_of[root]) && steps < TABLE_DEPTH)
        begin
            root = parent_of[root][CNT_W-1:0];
            steps++;
        end
        steps = 0;
        while (walk != root && is_link(parent_of[walk]) && steps < TABLE_DEPTH)
        begin
            next_node       = parent_of[walk][CNT_W-1:0];
            parent_of[walk] = {1'b0, root};
            walk            = next_node;
            steps++;
        end
        return root;
    endfunction

    function automatic outcome_t predict_outcome(input logic opc,
                                                 input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        outcome_t         r;
        logic [CNT_W-1:0] ra;
        logic [CNT_W-1:0] rb;
        r.same_set    = 1'b0;
        r.index_error = 1'b0;
        if (a < 1 || a > node_limit || b < 1 || b > node_limit)
        begin
            r.index_error = 1'b1;
        end
        else
        begin
            ra = locate_root(a);
            rb = locate_root(b);
            r.same_set = (ra == rb);
            if (opc == OP_JOIN && !r.same_set)
            begin
                if (parent_of[ra] < parent_of[rb])
                begin
                    parent_of[ra] = parent_of[ra] + parent_of[rb];
                    parent_of[rb] = {1'b0, ra};
                end
                else
                begin
                    parent_of[rb] = parent_of[rb] + parent_of[ra];
                    parent_of[ra] = {1'b0, rb};
                end
                merged_sets = merged_sets + 1'b1;
                total_merges++;
            end
        end
        r.component_count = node_limit - merged_sets;
        return r;
    endfunction

    function automatic void apply_node_count(input logic [CNT_W-1:0] value);
        if (value < 1)
            node_limit = CNT_W'(1);
        else if (value > TABLE_DEPTH)
            node_limit = CNT_W'(TABLE_DEPTH);
        else
            node_limit = value;
        for (int i = 0; i <= TABLE_DEPTH; i++)
            parent_of[i] = -12'sd1;
        merged_sets = '0;
    endfunction

    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_off_cycles--;
        end
        else if (no_idle)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 28);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result with no transaction outstanding");
                error_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                results_checked++;
                if (same_set !== want.same_set)
                begin
                    $error("same_set: expected %0d, actual %0d", want.same_set, same_set);
                    error_count++;
                end
                if (component_count !== want.component_count)
                begin
                    $error("component_count: expected %0d, actual %0d",
                           want.component_count, component_count);
                    error_count++;
                end
                if (index_error !== want.index_error)
                begin
                    $error("index_error: expected %0d, actual %0d",
                           want.index_error, index_error);
                    error_count++;
                end
            end
        end
    end

    task automatic send_item(input logic opc, input logic [CNT_W-1:0] a,
                             input logic [CNT_W-1:0] b);
        while (!no_idle && $urandom_range(0, 99) < 28)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= opc;
        first_node  <= a;
        second_node <= b;
        do
            @(posedge clk);
        while (!in_ready);
        pending_outcomes.push_back(predict_outcome(opc, a, b));
        transactions_sent++;
        @(negedge clk);
    endtask

    task automatic send_random(input int span);
        logic             opc;
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
        opc = 1'($urandom_range(0, 1));
        a   = CNT_W'($urandom_range(1, span));
        b   = CNT_W'($urandom_range(1, span));
        if ($urandom_range(0, 99) < 12)
        begin
            if ($urandom_range(0, 1))
                a = CNT_W'($urandom_range(0, 2047));
            else
                b = CNT_W'($urandom_range(0, 2047));
        end
        send_item(opc, a, b);
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_node_count(input logic [CNT_W-1:0] value);
        quiesce();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_node_count(value);
        settings_used++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_index_limits();
        send_item(OP_CHECK, 11'd1, 11'd1024);
        send_item(OP_JOIN, 11'd1024, 11'd1);
        send_item(OP_CHECK, 11'd0, 11'd5);
        send_item(OP_JOIN, 11'd5, 11'd0);
        send_item(OP_CHECK, 11'd1025, 11'd1);
        send_item(OP_JOIN, 11'd2047, 11'd2047);
        send_item(OP_CHECK, 11'd1024, 11'd1);
    endtask

    task automatic test_small_forest();
        write_node_count(11'd8);
        // Equal sizes put the first root under the second.
        send_item(OP_JOIN, 11'd1, 11'd2);
        send_item(OP_JOIN, 11'd3, 11'd4);
        send_item(OP_JOIN, 11'd1, 11'd3);
        // A singleton joins a larger set and hangs under its root.
        send_item(OP_JOIN, 11'd5, 11'd1);
        send_item(OP_JOIN, 11'd2, 11'd4);
        send_item(OP_CHECK, 11'd1, 11'd5);
        send_item(OP_CHECK, 11'd6, 11'd7);
        send_item(OP_JOIN, 11'd7, 11'd7);
        send_item(OP_CHECK, 11'd9, 11'd1);
        send_item(OP_JOIN, 11'd8, 11'd9);
        send_item(OP_JOIN, 11'd8, 11'd6);
    endtask

    task automatic test_count_saturation();
        write_node_count(11'd0);
        send_item(OP_CHECK, 11'd1, 11'd1);
        send_item(OP_JOIN, 11'd1, 11'd1);
        send_item(OP_JOIN, 11'd1, 11'd2);
        write_node_count(11'd2047);
        send_item(OP_CHECK, 11'd1024, 11'd1023);
    endtask

    task automatic test_random_forests();
        write_node_count(11'd16);
        repeat (150) send_random(16);
        write_node_count(11'd64);
        repeat (250) send_random(64);
        write_node_count(11'd2);
        repeat (50) send_random(2);
    endtask

    task automatic test_full_table();
        write_node_count(11'd1024);
        repeat (60) send_random(1024);
        repeat (190) send_random(96);
        write_node_count(11'd1000);
        repeat (150) send_random(1000);
    endtask

    task automatic test_back_to_back();
        write_node_count(11'd300);
        no_idle = 1'b1;
        repeat (200) send_random(120);
        no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        write_node_count(11'd32);
        hold_off_cycles = 400;
        repeat (60) send_random(32);
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        op                = OP_CHECK;
        first_node        = '0;
        second_node       = '0;
        out_ready         = 1'b0;
        cfg_valid         = 1'b0;
        cfg_data          = '0;
        error_count       = 0;
        transactions_sent = 0;
        results_checked   = 0;
        settings_used     = 0;
        total_merges      = 0;
        hold_off_cycles   = 0;
        no_idle           = 1'b0;
        apply_node_count(11'd1024);
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_index_limits();
        test_small_forest();
        test_count_saturation();
        test_random_forests();
        test_full_table();
        test_back_to_back();
        test_output_stall();

        quiesce();
        repeat (16) @(posedge clk);
        $display("Checked %0d results from %0d transactions across %0d node_count writes.",
                 results_checked, transactions_sent, settings_used);
        $display("The predicted table merged sets %0d times.", total_merges);
        if (error_count == 0)
            $display("disjoint_set_union_find_test: clean");
        else
            $display("disjoint_set_union_find_test: errors");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Run did not finish in time.");
        $display("disjoint_set_union_find_test: errors");
        $finish;
    end

endmodule

// ===== files.f =====
sv/dsu_pkg.sv
sv/dsu_ctrl.sv
sv/dsu_datapath.sv
sv/disjoint_set_union_find.sv
sv/dsu_checker.sv
verif/disjoint_set_union_find_test.sv
